// ----- rtl/tli_pkg.sv -----
// Shared types and constants for the table linear interpolator.
package tli_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int DIFF_W = 33;
  localparam int QUO_W  = 36;
  localparam int Q_W    = 35;
  localparam int STEP_W = 6;

  // Narrow test: dx * DX_SCALE below one in fixed point
  localparam longint DX_SCALE = 100000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] mx;
    logic [DIFF_W-1:0] my;
    logic [DIFF_W-1:0] dx;
  } md_req_t;

  // Reply from the shared multiply/divide unit
  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] q;
  } md_rsp_t;

endpackage

// ----- rtl/tli_table.sv -----
// Key and value memories: one write port, one registered read port.
module tli_table import tli_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wkey,
  input  logic [DATA_W-1:0] wval,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rkey,
  output logic [DATA_W-1:0] rval
);

  logic [DATA_W-1:0] key_mem [DEPTH];
  logic [DATA_W-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

// ----- rtl/tli_muldiv.sv -----
// Shared add/subtract unit: shift-add multiply, restoring divide, rounding.
module tli_muldiv import tli_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_MUL  = 6'b000010,
    M_OVF  = 6'b000100,
    M_DIV  = 6'b001000,
    M_RND  = 6'b010000,
    M_DONE = 6'b100000
  } mstate_t;

  mstate_t           st, st_next;
  logic [STEP_W-1:0] cnt;
  logic [DIFF_W-1:0] mx, dx;
  logic [DIFF_W-1:0] acc;
  logic [DIFF_W-1:0] lo;
  logic [DIFF_W-1:0] rem;
  logic [QUO_W-1:0]  quo;
  logic              ovf;
  logic [Q_W-1:0]    q;

  logic [DIFF_W:0]   op_a, op_b;
  logic              op_sub;
  logic [DIFF_W+1:0] res;
  logic              res_ge;
  logic [QUO_W-1:0]  q_inc;

  // Operand selection for the one adder
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (st)
      M_MUL: begin
        op_a = {1'b0, acc};
        op_b = lo[0] ? {1'b0, mx} : '0;
      end
      M_OVF: begin
        op_a   = {1'b0, rem};
        op_b   = {1'b0, dx};
        op_sub = 1'b1;
      end
      M_DIV: begin
        op_a   = {rem, quo[QUO_W-1]};
        op_b   = {1'b0, dx};
        op_sub = 1'b1;
      end
      M_RND: begin
        op_a   = {rem, 1'b0};
        op_b   = {1'b0, dx};
        op_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign res    = {1'b0, op_a} + (op_sub ? ~{1'b0, op_b} : {1'b0, op_b})
                  + {{(DIFF_W+1){1'b0}}, op_sub};
  assign res_ge = ~res[DIFF_W+1];
  assign q_inc  = quo + {{(QUO_W-1){1'b0}}, res_ge};

  // Sequencer
  always_comb begin
    st_next = st;
    unique case (st)
      M_IDLE: if (req.start) st_next = M_MUL;
      M_MUL:  if (cnt == STEP_W'(DIFF_W - 1)) st_next = M_OVF;
      M_OVF:  st_next = M_DIV;
      M_DIV:  if (cnt == STEP_W'(QUO_W - 1)) st_next = M_RND;
      M_RND:  st_next = M_DONE;
      M_DONE: st_next = M_IDLE;
      default: st_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (st)
      M_IDLE: begin
        mx  <= req.mx;
        dx  <= req.dx;
        lo  <= req.my;
        acc <= '0;
        cnt <= '0;
      end
      M_MUL: begin
        acc <= res[DIFF_W:1];
        lo  <= {res[0], lo[DIFF_W-1:1]};
        cnt <= (cnt == STEP_W'(DIFF_W - 1)) ? '0 : cnt + STEP_W'(1);
      end
      M_OVF: begin
        // Quotient too large for the low quotient bits: saturate later
        ovf <= res_ge;
      end
      M_DIV: begin
        rem <= res_ge ? res[DIFF_W-1:0] : op_a[DIFF_W-1:0];
        quo <= {quo[QUO_W-2:0], res_ge};
        cnt <= cnt + STEP_W'(1);
      end
      M_RND: begin
        if (ovf || q_inc > QUO_W'(1) << (Q_W - 1)) q <= Q_W'(1) << (Q_W - 1);
        else q <= q_inc[Q_W-1:0];
      end
      M_DONE: ;
      default: ;
    endcase
    // Split the product into the first partial remainder and the low bits
    if (st == M_MUL && cnt == STEP_W'(DIFF_W - 1)) begin
      rem <= DIFF_W'(res[DIFF_W:4]);
      quo <= {res[3:1], res[0], lo[DIFF_W-1:1]};
    end
  end

  assign rsp.busy = (st != M_IDLE);
  assign rsp.done = (st == M_DONE);
  assign rsp.q    = q;

endmodule

// ----- rtl/table_linear_interpolator.sv -----
// Piecewise-linear table lookup: bisection search plus shared multiply/divide.
// A query runs the bisection probes, fetches the segment, runs the shared adder (multiply,
// overflow check, divide, round, done) and loads the output register. A new beat is taken
// only in S_IDLE, once the last query is through; an exact key hit ends the search early, a
// narrow segment skips the shared adder, a held output stalls. A write beat is written as
// it is accepted. Reset is synchronous: control clears, entries_in_use returns to 1024,
// table contents are undefined until written.
module table_linear_interpolator import tli_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [DATA_W-1:0] key_value,
  input  logic [DATA_W-1:0] table_value,
  input  logic [DATA_W-1:0] query_x,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result_y,
  output logic [IDX_W-1:0]  segment_index,
  output logic              narrow_interval,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 2);
  localparam longint NARROW_LIM = ((64'sd1 <<< FRAC_BITS) + DX_SCALE - 1) / DX_SCALE;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PROBE = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_SEG   = 9'b000001000,
    S_RDLO  = 9'b000010000,
    S_RDHI  = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t             st, st_next;
  logic [CNT_W-1:0]   entries_in_use;
  logic [CW-1:0]      n_eff, n_q;
  logic [CW-1:0]      above, below, pos;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      seg_calc;
  logic [AW-1:0]      seg, raddr;
  logic [DATA_W-1:0]  x_q, xl, yl;
  logic [DIFF_W-1:0]  dx, dxq, dy;
  logic               neg;
  logic [DATA_W-1:0]  rkey, rval;
  logic               in_acc, tbl_we;
  logic               key_eq, key_lt;
  logic               narrow;
  logic [Q_W+1:0]     y_sum;
  logic [DATA_W-1:0]  y_sat;
  md_req_t            md_req;
  md_rsp_t            md_rsp;

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign tbl_we    = in_acc && opcode == OP_WRITE &&
                     ({22'b0, entry_index} < 32'(TABLE_DEPTH));

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  // Effective count, clamped to [3, TABLE_DEPTH]
  always_comb begin
    priority if ({21'b0, entries_in_use} < 32'd3) n_eff = CW'(3);
    else if ({21'b0, entries_in_use} > 32'(TABLE_DEPTH)) n_eff = CW'(TABLE_DEPTH);
    else n_eff = CW'(entries_in_use);
  end

  // Search and segment arithmetic
  assign mid_sum = {1'b0, above} + {1'b0, below};
  assign mid     = mid_sum[CW:1];
  assign key_eq  = ($signed(x_q) == $signed(rkey));
  assign key_lt  = ($signed(x_q) <  $signed(rkey));

  always_comb begin
    priority if (pos == '0) seg_calc = '0;
    else if (pos > n_q - CW'(2)) seg_calc = n_q - CW'(3);
    else seg_calc = pos - CW'(1);
  end

  always_comb begin
    priority if (st == S_SEG) raddr = AW'(seg_calc);
    else if (st == S_RDLO) raddr = seg + AW'(1);
    else raddr = AW'(mid - CW'(1));
  end

  assign narrow = ($signed(dx) < $signed(DIFF_W'(NARROW_LIM)));

  // Final add and saturation
  assign y_sum = neg ? {{(Q_W-DATA_W+2){yl[DATA_W-1]}}, yl} - {2'b0, md_rsp.q}
                     : {{(Q_W-DATA_W+2){yl[DATA_W-1]}}, yl} + {2'b0, md_rsp.q};
  always_comb begin
    priority if ($signed(y_sum) > $signed((Q_W+2)'(32'h7fffffff)))
      y_sat = 32'h7fffffff;
    else if ($signed(y_sum) < -$signed((Q_W+2)'(33'h080000000)))
      y_sat = 32'h80000000;
    else y_sat = y_sum[DATA_W-1:0];
  end

  // Sequencer
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:  if (in_acc && opcode == OP_QUERY) st_next = S_PROBE;
      S_PROBE: st_next = (above - below > CW'(1)) ? S_CMP : S_SEG;
      S_CMP:   st_next = key_eq ? S_SEG : S_PROBE;
      S_SEG:   st_next = S_RDLO;
      S_RDLO:  st_next = S_RDHI;
      S_RDHI:  st_next = S_CHK;
      S_CHK:   st_next = narrow ? S_OUT : S_MUL;
      S_MUL:   if (md_rsp.done) st_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        x_q   <= query_x;
        n_q   <= n_eff;
        above <= n_eff + CW'(1);
        below <= '0;
      end
      S_PROBE: if (!(above - below > CW'(1))) pos <= below;
      S_CMP: begin
        if (key_eq) pos <= mid;
        else if (key_lt) above <= mid;
        else below <= mid;
      end
      S_SEG:  seg <= AW'(seg_calc);
      S_RDLO: begin
        xl <= rkey;
        yl <= rval;
      end
      S_RDHI: begin
        dx  <= {rkey[DATA_W-1], rkey} - {xl[DATA_W-1], xl};
        dxq <= {x_q[DATA_W-1], x_q} - {xl[DATA_W-1], xl};
        dy  <= {rval[DATA_W-1], rval} - {yl[DATA_W-1], yl};
      end
      S_CHK:  neg <= (dxq[DIFF_W-1] != dy[DIFF_W-1]);
      default: ;
    endcase
  end

  assign md_req.start = (st == S_CHK) && !narrow;
  assign md_req.mx    = dxq[DIFF_W-1] ? -dxq : dxq;
  assign md_req.my    = dy[DIFF_W-1] ? -dy : dy;
  assign md_req.dx    = dx;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_OUT && (!out_valid || out_ready)) begin
      narrow_interval <= narrow;
      result_y        <= narrow ? yl : y_sat;
      segment_index   <= IDX_W'(seg);
    end
  end

  tli_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(entry_index)),
    .wkey  (key_value),
    .wval  (table_value),
    .raddr (raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  tli_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Checks
  a_idle_md: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !md_rsp.busy) else $error("divider busy while idle");
  a_done_mul: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> st == S_MUL) else $error("divider done outside wait");
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (rst)
    st == S_CMP |-> $past(st) == S_PROBE) else $error("compare without probe");
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    st == S_OUT |-> {1'b0, CW'(seg)} + (CW+1)'(3) <= {1'b0, n_q})
    else $error("segment past clamp");

endmodule
